// ===== design/ps2mc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mc_pkg: shared types and constants of the PS/2 mouse packet cursor
// Queue word layout, operation codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic CSR_H_RES = 1'b0;
   localparam logic CSR_V_RES = 1'b1;

   localparam logic [15:0] H_RES_RESET      = 16'd800;
   localparam logic [15:0] V_RES_RESET      = 16'd600;
   localparam logic [15:0] CURSOR_COL_RESET = 16'd400;
   localparam logic [15:0] CURSOR_ROW_RESET = 16'd300;

   localparam int SYNC_BIT = 3;

   localparam logic [1:0] LAST_BYTE_INDEX = 2'd2;

   typedef enum logic {
      CMD_PACKET = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   byte0;
      logic [7:0]   byte1;
      logic [7:0]   byte2;
   } queue_word_type;

endpackage

// ===== design/ps2mc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mc_front: byte filter and packet framer
// Drops bytes without both status flags and first bytes without the sync bit,
// frames three-byte packets, queues them and clear commands for the back end.
// ----------------------------------------------------------------------------
module ps2mc_front
   import ps2mc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_operation,
   input  logic           req_output_full,
   input  logic           req_from_aux,
   input  logic [7:0]     req_data_byte,
   output logic           push_valid,
   output queue_word_type push_word,
   input  logic           queue_full
);

   logic [1:0] byte_index_ff, byte_index_in;
   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic       accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      byte_index_in   = byte_index_ff;
      held0_in        = held0_ff;
      held1_in        = held1_ff;
      push_valid      = 1'b0;
      push_word.kind  = CMD_PACKET;
      push_word.byte0 = held0_ff;
      push_word.byte1 = held1_ff;
      push_word.byte2 = req_data_byte;
      if (accept) begin
         if (req_operation == OP_CLEAR) begin
            byte_index_in  = '0;
            push_valid     = 1'b1;
            push_word.kind = CMD_CLEAR;
         end else if (req_output_full && req_from_aux) begin
            priority if (byte_index_ff == 2'd0 && !req_data_byte[SYNC_BIT]) begin
               byte_index_in = byte_index_ff;
            end else if (byte_index_ff == 2'd0) begin
               held0_in      = req_data_byte;
               byte_index_in = 2'd1;
            end else if (byte_index_ff != LAST_BYTE_INDEX) begin
               held1_in      = req_data_byte;
               byte_index_in = LAST_BYTE_INDEX;
            end else begin
               byte_index_in = '0;
               push_valid    = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
      end else begin
         byte_index_ff <= byte_index_in;
      end
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

// ===== design/ps2mc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mc_queue: two-entry queue between framer and cursor unit
// Lets the framer keep taking bytes while a result waits downstream.
// ----------------------------------------------------------------------------
module ps2mc_queue
   import ps2mc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  queue_word_type push_word,
   output logic           queue_full,
   output logic           pop_avail,
   input  logic           pop,
   output queue_word_type pop_word
);

   queue_word_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_pop;

   assign queue_full = (count_ff == 2'd2);
   assign pop_avail  = (count_ff != 2'd0);
   assign do_pop     = pop && pop_avail;
   assign pop_word   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== design/ps2mc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mc_back: cursor unit and result register
// Decodes queued packets, moves and clamps the cursor, counts packets and
// holds the result word until it is taken.
// ----------------------------------------------------------------------------
module ps2mc_back
   import ps2mc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [15:0]       csr_write_data,
   input  logic              pop_avail,
   output logic              pop,
   input  queue_word_type    pop_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_left_button,
   output logic              rsp_right_button,
   output logic              rsp_middle_button,
   output logic              rsp_x_overflow,
   output logic              rsp_y_overflow,
   output logic signed [8:0] rsp_delta_x,
   output logic signed [8:0] rsp_delta_y,
   output logic              rsp_moved,
   output logic [15:0]       rsp_cursor_x,
   output logic [15:0]       rsp_cursor_y,
   output logic [31:0]       rsp_packet_count
);

   logic [15:0] width_ff, height_ff;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [31:0] count_ff, count_in;
   logic        valid_ff, valid_in;
   logic [7:0]  b0_ff;
   logic [8:0]  dx_ff, dy_ff;
   logic        moved_ff;

   logic [8:0]  dx, dy;
   logic [17:0] sum_x, sum_y;
   logic [15:0] lim_x, lim_y;
   logic [15:0] next_col, next_row;
   logic        take_packet;

   assign pop         = pop_avail && (!valid_ff || rsp_ready);
   assign take_packet = pop && (pop_word.kind == CMD_PACKET);

   assign dx    = {pop_word.byte0[4], pop_word.byte1};
   assign dy    = {pop_word.byte0[5], pop_word.byte2};
   assign sum_x = {2'b00, col_ff} + {{9{dx[8]}}, dx};
   assign sum_y = {2'b00, row_ff} - {{9{dy[8]}}, dy};
   assign lim_x = (width_ff == 16'd0) ? 16'd0 : width_ff - 16'd1;
   assign lim_y = (height_ff == 16'd0) ? 16'd0 : height_ff - 16'd1;

   always_comb begin
      priority if (sum_x[17]) begin
         next_col = 16'd0;
      end else if (sum_x[16:0] > {1'b0, lim_x}) begin
         next_col = lim_x;
      end else begin
         next_col = sum_x[15:0];
      end
      priority if (sum_y[17]) begin
         next_row = 16'd0;
      end else if (sum_y[16:0] > {1'b0, lim_y}) begin
         next_row = lim_y;
      end else begin
         next_row = sum_y[15:0];
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      count_in = count_ff;
      valid_in = rsp_ready ? 1'b0 : valid_ff;
      if (pop) begin
         unique case (pop_word.kind)
            CMD_CLEAR: begin
               count_in = '0;
            end
            CMD_PACKET: begin
               col_in   = next_col;
               row_in   = next_row;
               count_in = count_ff + 32'd1;
               valid_in = 1'b1;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= H_RES_RESET;
         height_ff <= V_RES_RESET;
         col_ff    <= CURSOR_COL_RESET;
         row_ff    <= CURSOR_ROW_RESET;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == CSR_H_RES) begin
            width_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == CSR_V_RES) begin
            height_ff <= csr_write_data;
         end
         col_ff   <= col_in;
         row_ff   <= row_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      if (take_packet) begin
         b0_ff    <= pop_word.byte0;
         dx_ff    <= dx;
         dy_ff    <= dy;
         moved_ff <= (dx != 9'd0) || (dy != 9'd0);
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_left_button   = b0_ff[0];
   assign rsp_right_button  = b0_ff[1];
   assign rsp_middle_button = b0_ff[2];
   assign rsp_x_overflow    = b0_ff[6];
   assign rsp_y_overflow    = b0_ff[7];
   assign rsp_delta_x       = $signed(dx_ff);
   assign rsp_delta_y       = $signed(dy_ff);
   assign rsp_moved         = moved_ff;
   assign rsp_cursor_x      = col_ff;
   assign rsp_cursor_y      = row_ff;
   assign rsp_packet_count  = count_ff;

endmodule

// ===== design/ps2_mouse_packet_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor: PS/2 mouse packet decoder with clamped cursor
// A packet is written into the queue when its last byte is accepted and is then
// moved by the cursor update into the result register once that register is free.
// Throughput: one word per cycle on both channels, set by the framer and the
// cursor update, while the result is taken; the two-entry queue absorbs stalls.
// Reset: byte index and packet count clear, cursor returns to 400, 300 and
// the resolution to 800 by 600; the held bytes are not cleared.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor
   import ps2mc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [15:0]       csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic              req_output_full,
   input  logic              req_from_aux,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_left_button,
   output logic              rsp_right_button,
   output logic              rsp_middle_button,
   output logic              rsp_x_overflow,
   output logic              rsp_y_overflow,
   output logic signed [8:0] rsp_delta_x,
   output logic signed [8:0] rsp_delta_y,
   output logic              rsp_moved,
   output logic [15:0]       rsp_cursor_x,
   output logic [15:0]       rsp_cursor_y,
   output logic [31:0]       rsp_packet_count
);

   logic           push_valid;
   queue_word_type push_word;
   logic           queue_full;
   logic           pop_avail;
   logic           pop;
   queue_word_type pop_word;

   ps2mc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_output_full (req_output_full),
      .req_from_aux    (req_from_aux),
      .req_data_byte   (req_data_byte),
      .push_valid      (push_valid),
      .push_word       (push_word),
      .queue_full      (queue_full)
   );

   ps2mc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .queue_full (queue_full),
      .pop_avail  (pop_avail),
      .pop        (pop),
      .pop_word   (pop_word)
   );

   ps2mc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .pop_avail         (pop_avail),
      .pop               (pop),
      .pop_word          (pop_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_button   (rsp_left_button),
      .rsp_right_button  (rsp_right_button),
      .rsp_middle_button (rsp_middle_button),
      .rsp_x_overflow    (rsp_x_overflow),
      .rsp_y_overflow    (rsp_y_overflow),
      .rsp_delta_x       (rsp_delta_x),
      .rsp_delta_y       (rsp_delta_y),
      .rsp_moved         (rsp_moved),
      .rsp_cursor_x      (rsp_cursor_x),
      .rsp_cursor_y      (rsp_cursor_y),
      .rsp_packet_count  (rsp_packet_count)
   );

endmodule
